[src/msh_pkg.sv]
`timescale 1ns / 1ps

package msh_pkg;

  localparam logic [2:0] ALG_DJB2     = 3'd0;
  localparam logic [2:0] ALG_FNV1A    = 3'd1;
  localparam logic [2:0] ALG_LOSELOSE = 3'd2;
  localparam logic [2:0] ALG_SDBM     = 3'd3;
  localparam logic [2:0] ALG_ELF      = 3'd4;
  localparam logic [2:0] ALG_JENKINS  = 3'd5;

  localparam logic [1:0] CFG_ALGORITHM     = 2'd0;
  localparam logic [1:0] CFG_WIDE_CHARS    = 2'd1;
  localparam logic [1:0] CFG_JENKINS_SHIFT = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 5;

  localparam logic [31:0] DJB2_SEED  = 32'd5381;
  localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
  localparam logic [31:0] ELF_TOP    = 32'hF000_0000;

  typedef struct packed {
    logic [2:0] alg;
    logic       wide;
    logic [4:0] shift;
  } cfg_t;

  typedef struct packed {
    logic [31:0] value;
    logic        valid;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        load;
    logic [31:0] seed;
  } reseed_t;

  function automatic logic [2:0] alg_sel(input logic [2:0] alg);
    return (alg > ALG_JENKINS) ? ALG_JENKINS : alg;
  endfunction

  function automatic logic [31:0] seed_of(input logic [2:0] alg);
    logic [31:0] s;
    unique case (alg)
      ALG_DJB2:  s = DJB2_SEED;
      ALG_FNV1A: s = FNV_OFFSET;
      default:   s = 32'd0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] h, input logic [31:0] c,
                                      input logic [2:0] alg, input logic [4:0] shift);
    logic [31:0] t;
    logic [31:0] top;
    logic [31:0] r;
    t   = 32'd0;
    top = 32'd0;
    unique case (alg)
      ALG_FNV1A:    r = (h ^ c) * FNV_PRIME;
      ALG_DJB2:     r = (h << 5) + h + c;
      ALG_LOSELOSE: r = h + c;
      ALG_SDBM:     r = c + (h << 6) + (h << 16) - h;
      ALG_ELF: begin
        t   = (h << 4) + c;
        top = t & ELF_TOP;
        r   = (t ^ (top >> 24)) & ~top;
      end
      default: begin
        t = h + c;
        t = t + (t << shift);
        r = t ^ (t >> 6);
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] finish(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

[src/msh_if.sv]
`timescale 1ns / 1ps

interface msh_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        char_valid;
  logic        last_char;

  modport source (output valid, output char_code, output char_valid, output last_char,
                  input ready);
  modport sink (input valid, input char_code, input char_valid, input last_char,
                output ready);
endinterface

interface msh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

[src/msh_front.sv]
`timescale 1ns / 1ps

module msh_front (
  msh_in_if.sink          in_ch,
  input  msh_pkg::cfg_t   cfg,
  input  logic            push_ready,
  output logic            push,
  output msh_pkg::item_t  push_item
);

  logic [31:0] char_ext;

  always_comb begin
    if (cfg.alg == msh_pkg::ALG_FNV1A) begin
      char_ext = {24'd0, in_ch.char_code[7:0]};
    end else if (cfg.wide) begin
      char_ext = {16'd0, in_ch.char_code};
    end else begin
      char_ext = {{24{in_ch.char_code[7]}}, in_ch.char_code[7:0]};
    end
  end

  assign in_ch.ready     = push_ready;
  assign push            = in_ch.valid && push_ready;
  assign push_item.value = char_ext;
  assign push_item.valid = in_ch.char_valid;
  assign push_item.last  = in_ch.last_char;

endmodule

[src/msh_queue.sv]
`timescale 1ns / 1ps

module msh_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  msh_pkg::item_t  push_item,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output msh_pkg::item_t  pop_item
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  msh_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/msh_back.sv]
`timescale 1ns / 1ps

module msh_back (
  input  logic              clk,
  input  logic              rst_n,
  input  msh_pkg::cfg_t     cfg,
  input  msh_pkg::reseed_t  reseed,
  input  logic              q_valid,
  input  msh_pkg::item_t    q_item,
  output logic              pop,
  msh_out_if.source         out_ch
);

  logic [31:0] hash_r;
  logic [31:0] hash_mix;
  logic        fin_valid_r;
  logic [31:0] fin_raw_r;
  logic        fin_jen_r;
  logic        out_valid_r;
  logic [31:0] out_hash_r;
  logic        out_free;
  logic        fin_adv;
  logic        fin_free;

  assign out_free = !out_valid_r || out_ch.ready;
  assign fin_adv  = fin_valid_r && out_free;
  assign fin_free = !fin_valid_r || fin_adv;
  assign pop      = q_valid && (!q_item.last || fin_free);
  assign hash_mix = q_item.valid ? msh_pkg::mix(hash_r, q_item.value, cfg.alg, cfg.shift)
                                 : hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= msh_pkg::seed_of(msh_pkg::ALG_JENKINS);
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (reseed.load) begin
        hash_r <= reseed.seed;
      end else if (pop) begin
        hash_r <= q_item.last ? msh_pkg::seed_of(cfg.alg) : hash_mix;
      end
      if (pop && q_item.last) begin
        fin_valid_r <= 1'b1;
      end else if (fin_adv) begin
        fin_valid_r <= 1'b0;
      end
      if (fin_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      fin_raw_r <= hash_mix;
      fin_jen_r <= (cfg.alg == msh_pkg::ALG_JENKINS);
    end
    if (fin_adv) begin
      out_hash_r <= fin_jen_r ? msh_pkg::finish(fin_raw_r) : fin_raw_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

endmodule

[src/multi_algorithm_string_hash.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Beat payload
// in_ch     in   valid/ready        char_code[15:0], char_valid, last_char
// out_ch    out  valid/ready        hash_value[31:0]
// cfg_*     in   cfg_we, no ready   cfg_index[1:0], cfg_wdata[4:0]
//
// One character beat per cycle while the queue has room; the running-hash register updates once per beat.
// The ending beat passes the queue, then its hash fin_raw_r and out_hash_r, before out_ch.
// rst_n is synchronous; after reset the block takes beats at once.
// in_ch stalls only when the QUEUE_DEPTH-entry queue between front and back fills.

module multi_algorithm_string_hash #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  msh_in_if.sink                            in_ch,
  msh_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [msh_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [msh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [2:0]        alg_r;
  logic              wide_r;
  logic [4:0]        shift_r;
  msh_pkg::cfg_t     cfg;
  msh_pkg::reseed_t  reseed;
  logic              push;
  logic              push_ready;
  msh_pkg::item_t    push_item;
  logic              pop;
  logic              q_valid;
  msh_pkg::item_t    q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r   <= msh_pkg::ALG_JENKINS;
      wide_r  <= 1'b0;
      shift_r <= 5'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msh_pkg::CFG_ALGORITHM:     alg_r   <= cfg_wdata[2:0];
        msh_pkg::CFG_WIDE_CHARS:    wide_r  <= cfg_wdata[0];
        msh_pkg::CFG_JENKINS_SHIFT: shift_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign cfg.alg     = msh_pkg::alg_sel(alg_r);
  assign cfg.wide    = wide_r;
  assign cfg.shift   = shift_r;
  assign reseed.load = cfg_we && (cfg_index == msh_pkg::CFG_ALGORITHM);
  assign reseed.seed = msh_pkg::seed_of(msh_pkg::alg_sel(cfg_wdata[2:0]));

  msh_front u_front (
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push       (push),
    .push_item  (push_item)
  );

  msh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  msh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .reseed  (reseed),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
